// File: design/prs_pkg.sv
`timescale 1ns / 1ps

package prs_pkg;

    // Set size and derived widths.
    localparam int MAX_PARTICLES = 1024;
    localparam int IDX_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int W_W    = 16;
    localparam int OBJ_W  = 8;
    localparam int ELEV_W = 16;
    localparam int ROT_W  = 15;
    localparam int R_W    = 16;
    localparam int SUM_W  = W_W + IDX_W;
    localparam int PROD_W = R_W + SUM_W;
    localparam int PAY_W  = W_W + OBJ_W + ELEV_W + ROT_W;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [W_W-1:0]    weight_t;
    typedef logic [R_W-1:0]    rand_t;

    // Prefix sum write issued by a load.
    typedef struct packed {
        logic en;
        idx_t addr;
        sum_t psum;
    } prs_wr_t;

    // Result capture request toward the output register stage.
    typedef struct packed {
        logic capture;
        logic empty;
        idx_t index;
    } prs_cap_t;

endpackage

// File: design/particle_resampler_top.sv
// Loads: busy stays low, so a load may follow every cycle.
// Draws: MUL, READ, then CMP and READ per search step, then CAP; done is registered from CAP.
// S, the number of search steps, is at most ceil(log2(N)) for N loaded particles; each step
// is one prefix sum memory read and one compare. An empty set answers in the cycle after the
// start; busy falls as done rises, so the next item can start then; done cannot be stalled.
// rst_n is asynchronous and active low; it empties the set; memories are not cleared.
`timescale 1ns / 1ps

module particle_resampler_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     op,
    input  logic                     first_of_set,
    input  logic [prs_pkg::W_W-1:0]    weight,
    input  logic [prs_pkg::OBJ_W-1:0]  object_number,
    input  logic [prs_pkg::ELEV_W-1:0] elevation,
    input  logic [prs_pkg::ROT_W-1:0]  rotation,
    input  logic [prs_pkg::R_W-1:0]    random_value,
    output logic                     done,
    output logic [prs_pkg::IDX_W-1:0]  selected_index,
    output logic [prs_pkg::OBJ_W-1:0]  chosen_object,
    output logic [prs_pkg::ELEV_W-1:0] chosen_elevation,
    output logic [prs_pkg::ROT_W-1:0]  chosen_rotation,
    output logic [prs_pkg::W_W-1:0]    chosen_weight,
    output logic                     no_particles
);

    import prs_pkg::*;

    sum_t             sum_rdata;
    idx_t             sum_raddr;
    idx_t             pay_raddr;
    logic [PAY_W-1:0] pay_wdata;
    logic [PAY_W-1:0] pay_rdata;
    prs_wr_t          wr;
    prs_cap_t         cap;

    logic             done_reg;
    idx_t             index_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             empty_reg;

    prs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .first_of_set (first_of_set),
        .weight       (weight),
        .random_value (random_value),
        .sum_rdata    (sum_rdata),
        .sum_raddr    (sum_raddr),
        .pay_raddr    (pay_raddr),
        .wr           (wr),
        .cap          (cap),
        .busy         (busy)
    );

    // Prefix sums, searched by the sequencer.
    prs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_PARTICLES)
    ) u_sum_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.psum),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Particle fields and weight, written alongside the prefix sum.
    assign pay_wdata = {weight, object_number, elevation, rotation};

    prs_ram #(
        .WIDTH (PAY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_pay_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cap.capture;
        end
    end

    // Result item register; an empty set reports all zeros.
    always_ff @(posedge clk)
    begin
        if (cap.capture)
        begin
            empty_reg <= cap.empty;
            index_reg <= cap.empty ? '0 : cap.index;
            pay_reg   <= cap.empty ? '0 : pay_rdata;
        end
    end

    assign done             = done_reg;
    assign no_particles     = empty_reg;
    assign selected_index   = index_reg;
    assign chosen_rotation  = pay_reg[ROT_W-1:0];
    assign chosen_elevation = pay_reg[ROT_W +: ELEV_W];
    assign chosen_object    = pay_reg[ROT_W+ELEV_W +: OBJ_W];
    assign chosen_weight    = pay_reg[ROT_W+ELEV_W+OBJ_W +: W_W];

endmodule

// File: design/prs_ram.sv
`timescale 1ns / 1ps

module prs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/prs_ctrl.sv
`timescale 1ns / 1ps

module prs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    input  logic              first_of_set,
    input  prs_pkg::weight_t  weight,
    input  prs_pkg::rand_t    random_value,
    input  prs_pkg::sum_t     sum_rdata,
    output prs_pkg::idx_t     sum_raddr,
    output prs_pkg::idx_t     pay_raddr,
    output prs_pkg::prs_wr_t  wr,
    output prs_pkg::prs_cap_t cap,
    output logic              busy
);

    import prs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_CAP  = 3'd4;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    sum_t       total_reg, total_next;
    idx_t       lo_reg, lo_next;
    idx_t       hi_reg, hi_next;
    idx_t       mid_reg, mid_next;
    rand_t      r_reg, r_next;
    prod_t      target_reg, target_next;

    logic [IDX_W:0] mid_sum;
    idx_t           mid_calc;
    prod_t          prod;
    prod_t          probe;
    cnt_t           last_idx;

    // Midpoint of the current search window.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[IDX_W:1];
    assign last_idx = count_reg - CNT_W'(1);

    // Target r times total, and the probed prefix sum scaled by 65536.
    assign prod  = PROD_W'(r_reg) * PROD_W'(total_reg);
    assign probe = {sum_rdata, {R_W{1'b0}}};

    assign sum_raddr = mid_calc;
    assign pay_raddr = lo_reg;
    assign busy      = (state_reg != S_IDLE);

    // Load bookkeeping and the binary search sequencer.
    always_comb
    begin
        cnt_t base_cnt;
        sum_t base_tot;
        base_cnt    = first_of_set ? '0 : count_reg;
        base_tot    = first_of_set ? '0 : total_reg;
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        r_next      = r_reg;
        target_next = target_reg;
        wr          = '0;
        cap         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_LOAD)
                    begin
                        // A load on a full set is dropped.
                        if (base_cnt < CNT_W'(MAX_PARTICLES))
                        begin
                            total_next = base_tot + SUM_W'(weight);
                            count_next = base_cnt + CNT_W'(1);
                            wr.en      = 1'b1;
                            wr.addr    = base_cnt[IDX_W-1:0];
                            wr.psum    = total_next;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        cap.capture = 1'b1;
                        cap.empty   = 1'b1;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = last_idx[IDX_W-1:0];
                        r_next     = random_value;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                target_next = prod;
                state_next  = S_READ;
            end
            S_READ:
            begin
                // When the window has closed, the payload read at lo is in flight.
                if (lo_reg == hi_reg)
                begin
                    state_next = S_CAP;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (probe >= target_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + IDX_W'(1);
                end
                state_next = S_READ;
            end
            S_CAP:
            begin
                cap.capture = 1'b1;
                cap.index   = lo_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Search working registers.
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        r_reg      <= r_next;
        target_reg <= target_next;
    end

endmodule

// File: design/prs_checker.sv
`timescale 1ns / 1ps

module prs_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    op,
    input logic                    done,
    input logic                    no_particles,
    input logic [prs_pkg::IDX_W-1:0] selected_index,
    input logic [prs_pkg::W_W-1:0]   chosen_weight
);

    // A result is only shown once the draw has finished.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // A load produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op) |=> !done)
        else $error("result after a load");

    // An accepted draw either answers at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op) |=> (busy || done))
        else $error("draw neither answered nor in progress");

    // An empty-set result carries index zero and zero weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_particles) |-> (selected_index == '0 && chosen_weight == '0))
        else $error("empty-set result with nonzero fields");

endmodule

bind particle_resampler_top prs_checker u_prs_checker (.*);
